[sv/drs_pkg.sv]
// Shared types and constants for the diffusion-reaction stencil.
// Used by every module of the block; depends on nothing.

package drs_pkg;

    // Grid limits (defaults for the top-level parameters)
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int MIN_DIM        = 3;

    // Field widths
    localparam int VALUE_BITS = 32;
    localparam int DIM_BITS   = 11;
    localparam int COEF_BITS  = 32;
    localparam int RES_BITS   = 48;
    localparam int IDX_BITS   = 10;
    localparam int CFG_BITS   = 2;

    // Fixed-point layout: values Q.24, coefficients Q.16, accumulator Q.64
    localparam int FRAC_BITS  = 24;
    localparam int ACC_SHIFT  = 40;
    localparam int LIN_BITS   = VALUE_BITS + 4;
    localparam int DIFF_BITS  = VALUE_BITS + 1;
    localparam int MUL1_BITS  = DIFF_BITS + COEF_BITS + 1;
    localparam int PROD_BITS  = 2 * VALUE_BITS + 1;
    localparam int SPLIT_BITS = 32;
    localparam int PHI_IN     = PROD_BITS - SPLIT_BITS;
    localparam int PLO_BITS   = SPLIT_BITS + COEF_BITS;
    localparam int PHI_BITS   = PHI_IN + COEF_BITS + 1;
    localparam int ACC_BITS   = 100;
    localparam int SH_BITS    = ACC_BITS - ACC_SHIFT;

    localparam logic signed [DIFF_BITS-1:0] ONE_Q24 = DIFF_BITS'(1) <<< FRAC_BITS;
    localparam logic signed [ACC_BITS-1:0]  ROUND_BIAS = ACC_BITS'(1) <<< (ACC_SHIFT - 1);
    localparam logic [RES_BITS-1:0] RES_MAX = {1'b0, {(RES_BITS-1){1'b1}}};
    localparam logic [RES_BITS-1:0] RES_MIN = {1'b1, {(RES_BITS-1){1'b0}}};

    // Configuration register indexes
    localparam logic [CFG_BITS-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_BITS-1:0] REG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_BITS-1:0] REG_ALPHA_COEFF = 2'd2;
    localparam logic [CFG_BITS-1:0] REG_BETA_COEFF  = 2'd3;

    // Position tag that travels with a result through the pipeline
    typedef struct packed {
        logic [IDX_BITS-1:0] x;
        logic [IDX_BITS-1:0] y;
        logic                last;
    } point_meta_t;

    // Stencil operands handed from the window to the arithmetic
    typedef struct packed {
        logic [LIN_BITS-1:0]   lin;
        logic [DIFF_BITS-1:0]  diff;
        logic [VALUE_BITS-1:0] center;
        logic [DIFF_BITS-1:0]  one_minus;
    } stencil_ops_t;

endpackage

[sv/drs_line_store.sv]
// Line stores of the stencil: two padded rows of new values, one of old values.
// Read-first synchronous memories with registered read data. Uses drs_pkg.

module drs_line_store #(
    parameter int MAX_WIDTH = drs_pkg::MAX_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  access_en,
    input  logic [$clog2(MAX_WIDTH+2)-1:0]        col,
    input  logic                                  row_odd,
    input  logic signed [drs_pkg::VALUE_BITS-1:0] new_value,
    input  logic signed [drs_pkg::VALUE_BITS-1:0] old_value,
    output logic signed [drs_pkg::VALUE_BITS-1:0] east_data,
    output logic signed [drs_pkg::VALUE_BITS-1:0] north_data,
    output logic signed [drs_pkg::VALUE_BITS-1:0] old_data
);

    localparam int ROW_SLOTS = MAX_WIDTH + 2;
    localparam int XW        = $clog2(ROW_SLOTS);
    localparam int NAW       = $clog2(2 * ROW_SLOTS);

    logic [drs_pkg::VALUE_BITS-1:0] new_line_mem [2*ROW_SLOTS];
    logic [drs_pkg::VALUE_BITS-1:0] old_line_mem [ROW_SLOTS];

    logic [XW-1:0]  col_east;
    logic [NAW-1:0] prev_base;
    logic [NAW-1:0] cur_base;
    logic [NAW-1:0] east_addr;
    logic [NAW-1:0] north_addr;
    logic [NAW-1:0] wr_addr;

    logic [drs_pkg::VALUE_BITS-1:0] east_data_reg;
    logic [drs_pkg::VALUE_BITS-1:0] north_data_reg;
    logic [drs_pkg::VALUE_BITS-1:0] old_data_reg;

    // Pick the row halves by parity; the last slot has no east neighbor
    always_comb
    begin
        col_east   = (col == XW'(ROW_SLOTS - 1)) ? col : col + XW'(1);
        prev_base  = row_odd ? NAW'(0) : NAW'(ROW_SLOTS);
        cur_base   = row_odd ? NAW'(ROW_SLOTS) : NAW'(0);
        east_addr  = prev_base + NAW'(col_east);
        // at column 0 the second port fetches the west seed of the row above
        north_addr = (col == XW'(0)) ? prev_base : cur_base + NAW'(col);
        wr_addr    = cur_base + NAW'(col);
    end

    // Read the old contents and write the incoming item in the same cycle
    always_ff @(posedge clk)
    begin
        if (access_en)
        begin
            east_data_reg        <= new_line_mem[east_addr];
            north_data_reg       <= new_line_mem[north_addr];
            new_line_mem[wr_addr] <= new_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (access_en)
        begin
            old_data_reg      <= old_line_mem[col];
            old_line_mem[col] <= old_value;
        end
    end

    assign east_data  = $signed(east_data_reg);
    assign north_data = $signed(north_data_reg);
    assign old_data   = $signed(old_data_reg);

endmodule

[sv/drs_window.sv]
// Stencil window: holds west and center of the row above and forms the operands.
// Takes line store read data, registered in step with the item. Uses drs_pkg.

module drs_window (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  accept,
    input  logic                                  has_result,
    input  logic                                  first_col,
    input  logic signed [drs_pkg::VALUE_BITS-1:0] south_value,
    input  drs_pkg::point_meta_t                  meta,
    input  logic signed [drs_pkg::VALUE_BITS-1:0] east_data,
    input  logic signed [drs_pkg::VALUE_BITS-1:0] north_data,
    input  logic signed [drs_pkg::VALUE_BITS-1:0] old_data,
    output logic                                  ops_valid,
    output drs_pkg::stencil_ops_t                 ops,
    output drs_pkg::point_meta_t                  ops_meta
);

    localparam int VB = drs_pkg::VALUE_BITS;
    localparam int LW = drs_pkg::LIN_BITS;
    localparam int DW = drs_pkg::DIFF_BITS;

    logic                 s1_valid_reg;
    logic                 s1_result_reg;
    logic                 s1_first_reg;
    logic signed [VB-1:0] s1_south_reg;
    drs_pkg::point_meta_t s1_meta_reg;

    logic signed [VB-1:0] hold_west_reg;
    logic signed [VB-1:0] hold_center_reg;

    logic                  ops_valid_reg;
    drs_pkg::stencil_ops_t ops_reg;
    drs_pkg::stencil_ops_t ops_next;
    drs_pkg::point_meta_t  ops_meta_reg;

    logic signed [LW-1:0] lin;
    logic signed [DW-1:0] diff;
    logic signed [DW-1:0] one_minus;

    // Capture the item alongside its memory reads
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_result_reg <= has_result;
            s1_first_reg  <= first_col;
            s1_south_reg  <= south_value;
            s1_meta_reg   <= meta;
        end
    end

    // Form the five-point sum and the two differences
    always_comb
    begin
        lin = LW'(hold_west_reg) + LW'(east_data) + LW'(north_data) + LW'(s1_south_reg)
              - (LW'(hold_center_reg) <<< 2);
        diff      = DW'(old_data) - DW'(hold_center_reg);
        one_minus = drs_pkg::ONE_Q24 - DW'(hold_center_reg);
        ops_next.lin       = lin;
        ops_next.diff      = diff;
        ops_next.center    = hold_center_reg;
        ops_next.one_minus = one_minus;
    end

    // Slide the row-above window; a row start seeds it from both ports
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_west_reg   <= '0;
            hold_center_reg <= '0;
        end
        else if (en && s1_valid_reg)
        begin
            if (s1_first_reg)
            begin
                hold_west_reg   <= north_data;
                hold_center_reg <= east_data;
            end
            else
            begin
                hold_west_reg   <= hold_center_reg;
                hold_center_reg <= east_data;
            end
        end
    end

    // Pass only points that produce a residual
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ops_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            ops_valid_reg <= s1_valid_reg && s1_result_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ops_reg      <= ops_next;
            ops_meta_reg <= s1_meta_reg;
        end
    end

    assign ops_valid = ops_valid_reg;
    assign ops       = ops_reg;
    assign ops_meta  = ops_meta_reg;

endmodule

[sv/drs_datapath.sv]
// Residual arithmetic: multiplies, wide accumulate, rounding and saturation.
// Four register stages ending in the output register. Uses drs_pkg.

module drs_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 ops_valid,
    input  drs_pkg::stencil_ops_t                ops,
    input  drs_pkg::point_meta_t                 ops_meta,
    input  logic [drs_pkg::COEF_BITS-1:0]        alpha_coeff,
    input  logic [drs_pkg::COEF_BITS-1:0]        beta_coeff,
    output logic                                 out_valid,
    output logic signed [drs_pkg::RES_BITS-1:0]  residual,
    output drs_pkg::point_meta_t                 out_meta,
    output logic                                 saturated
);

    localparam int LW  = drs_pkg::LIN_BITS;
    localparam int DW  = drs_pkg::DIFF_BITS;
    localparam int VB  = drs_pkg::VALUE_BITS;
    localparam int CB  = drs_pkg::COEF_BITS;
    localparam int M1  = drs_pkg::MUL1_BITS;
    localparam int PW  = drs_pkg::PROD_BITS;
    localparam int SB  = drs_pkg::SPLIT_BITS;
    localparam int PHI = drs_pkg::PHI_IN;
    localparam int PLW = drs_pkg::PLO_BITS;
    localparam int PHW = drs_pkg::PHI_BITS;
    localparam int AW  = drs_pkg::ACC_BITS;
    localparam int SHW = drs_pkg::SH_BITS;
    localparam int RB  = drs_pkg::RES_BITS;

    // multiply stage
    logic                  mul_valid_reg;
    logic signed [LW-1:0]  mul_lin_reg;
    logic signed [M1-1:0]  alpha_term_reg;
    logic signed [PW-1:0]  prod_reg;
    drs_pkg::point_meta_t  mul_meta_reg;
    logic signed [M1-1:0]  alpha_term_next;
    logic signed [PW-1:0]  prod_next;
    logic signed [CB:0]    alpha_s;
    logic signed [CB:0]    beta_s;

    // partial product stage
    logic                  part_valid_reg;
    logic [PLW-1:0]        p_lo_reg;
    logic signed [PHW-1:0] p_hi_reg;
    logic signed [AW-1:0]  sum_b_reg;
    drs_pkg::point_meta_t  part_meta_reg;
    logic [PLW-1:0]        p_lo_next;
    logic signed [PHW-1:0] p_hi_next;
    logic signed [AW-1:0]  sum_b_next;
    logic signed [PHI-1:0] prod_hi;

    // accumulate stage
    logic                  acc_valid_reg;
    logic signed [AW-1:0]  acc_reg;
    drs_pkg::point_meta_t  acc_meta_reg;
    logic signed [AW-1:0]  acc_next;

    // output stage
    logic                  out_valid_reg;
    logic [RB-1:0]         residual_reg;
    logic                  saturated_reg;
    drs_pkg::point_meta_t  out_meta_reg;
    logic [SHW-1:0]        shifted;
    logic                  in_range;
    logic [RB-1:0]         residual_next;

    assign alpha_s = $signed({1'b0, alpha_coeff});
    assign beta_s  = $signed({1'b0, beta_coeff});

    // alpha*(old-c) and c*(1-c)
    always_comb
    begin
        alpha_term_next = M1'($signed(ops.diff)) * M1'(alpha_s);
        prod_next       = PW'($signed(ops.center)) * PW'($signed(ops.one_minus));
    end

    // Split c*(1-c) for the beta product; line up the linear terms
    always_comb
    begin
        prod_hi    = prod_reg[PW-1:SB];
        p_lo_next  = PLW'(prod_reg[SB-1:0]) * PLW'(beta_coeff);
        p_hi_next  = PHW'(prod_hi) * PHW'(beta_s);
        sum_b_next = (AW'(mul_lin_reg) <<< drs_pkg::ACC_SHIFT)
                     + (AW'(alpha_term_reg) <<< drs_pkg::FRAC_BITS)
                     + drs_pkg::ROUND_BIAS;
    end

    // Sum everything at Q.64
    always_comb
    begin
        acc_next = sum_b_reg + $signed({{(AW-PLW){1'b0}}, p_lo_reg})
                   + (AW'(p_hi_reg) <<< SB);
    end

    // Drop the fraction and clip to the result range
    always_comb
    begin
        shifted  = acc_reg[AW-1:drs_pkg::ACC_SHIFT];
        in_range = (&shifted[SHW-1:RB-1]) || !(|shifted[SHW-1:RB-1]);
        if (in_range)
        begin
            residual_next = shifted[RB-1:0];
        end
        else if (shifted[SHW-1])
        begin
            residual_next = drs_pkg::RES_MIN;
        end
        else
        begin
            residual_next = drs_pkg::RES_MAX;
        end
    end

    // Advance the valid flags with the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg  <= 1'b0;
            part_valid_reg <= 1'b0;
            acc_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else if (en)
        begin
            mul_valid_reg  <= ops_valid;
            part_valid_reg <= mul_valid_reg;
            acc_valid_reg  <= part_valid_reg;
            out_valid_reg  <= acc_valid_reg;
        end
    end

    // Advance the payload with the pipeline
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mul_lin_reg    <= $signed(ops.lin);
            alpha_term_reg <= alpha_term_next;
            prod_reg       <= prod_next;
            mul_meta_reg   <= ops_meta;

            p_lo_reg       <= p_lo_next;
            p_hi_reg       <= p_hi_next;
            sum_b_reg      <= sum_b_next;
            part_meta_reg  <= mul_meta_reg;

            acc_reg        <= acc_next;
            acc_meta_reg   <= part_meta_reg;

            residual_reg   <= residual_next;
            saturated_reg  <= !in_range;
            out_meta_reg   <= acc_meta_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign residual  = $signed(residual_reg);
    assign out_meta  = out_meta_reg;
    assign saturated = saturated_reg;

endmodule

[sv/diffusion_reaction_stencil.sv]
// Fisher-KPP five-point diffusion-reaction residual engine, top level.
// Depends on drs_pkg, drs_line_store, drs_window and drs_datapath.
//
// The block takes a padded frame of (grid_width+2) x (grid_height+2) points in
// raster order and returns one saturated Q24.24 residual per interior point, in
// raster order, when the padded point below it arrives. It accepts one item per
// clock cycle unless the output is held; the line store reads two new-value and
// one old-value entry and writes one of each per cycle, which sets that rate. A
// residual passes the window and datapath registers. A held output stalls the
// whole pipeline and the input together. The line stores hold no reset value and
// need no clearing pass: a frame writes every entry before a result uses it.

module diffusion_reaction_stencil #(
    parameter int MAX_WIDTH  = drs_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = drs_pkg::MAX_HEIGHT_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [drs_pkg::VALUE_BITS-1:0] new_value,
    input  logic signed [drs_pkg::VALUE_BITS-1:0] old_value,
    input  logic                                  frame_start,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [drs_pkg::RES_BITS-1:0]   residual,
    output logic [drs_pkg::IDX_BITS-1:0]          point_x,
    output logic [drs_pkg::IDX_BITS-1:0]          point_y,
    output logic                                  frame_last,
    output logic                                  saturated,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [drs_pkg::CFG_BITS-1:0]          cfg_index,
    input  logic [drs_pkg::COEF_BITS-1:0]         cfg_data
);

    localparam int XW = $clog2(MAX_WIDTH + 2);
    localparam int YW = $clog2(MAX_HEIGHT + 2);
    localparam int DB = drs_pkg::DIM_BITS;
    localparam int CB = drs_pkg::COEF_BITS;

    logic [DB-1:0] grid_width_reg;
    logic [DB-1:0] grid_height_reg;
    logic [CB-1:0] alpha_coeff_reg;
    logic [CB-1:0] beta_coeff_reg;

    logic [XW-1:0] col_reg;
    logic [YW-1:0] row_reg;
    logic [XW-1:0] px;
    logic [YW-1:0] py;
    logic [XW-1:0] w_eff;
    logic [YW-1:0] h_eff;
    logic [XW-1:0] w_end;
    logic [YW-1:0] h_end;

    logic                 en;
    logic                 accept;
    logic                 has_result;
    drs_pkg::point_meta_t meta;

    logic signed [drs_pkg::VALUE_BITS-1:0] east_data;
    logic signed [drs_pkg::VALUE_BITS-1:0] north_data;
    logic signed [drs_pkg::VALUE_BITS-1:0] old_data;

    logic                  ops_valid;
    drs_pkg::stencil_ops_t ops;
    drs_pkg::point_meta_t  ops_meta;
    drs_pkg::point_meta_t  out_meta;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= DB'(128);
            grid_height_reg <= DB'(128);
            alpha_coeff_reg <= '0;
            beta_coeff_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                drs_pkg::REG_GRID_WIDTH:  grid_width_reg  <= cfg_data[DB-1:0];
                drs_pkg::REG_GRID_HEIGHT: grid_height_reg <= cfg_data[DB-1:0];
                drs_pkg::REG_ALPHA_COEFF: alpha_coeff_reg <= cfg_data;
                drs_pkg::REG_BETA_COEFF:  beta_coeff_reg  <= cfg_data;
                default:                  alpha_coeff_reg <= alpha_coeff_reg;
            endcase
        end
    end

    // Clamp the grid size to the supported range
    always_comb
    begin
        if (grid_width_reg < DB'(drs_pkg::MIN_DIM))
        begin
            w_eff = XW'(drs_pkg::MIN_DIM);
        end
        else if (32'(grid_width_reg) > 32'(MAX_WIDTH))
        begin
            w_eff = XW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = XW'(grid_width_reg);
        end

        if (grid_height_reg < DB'(drs_pkg::MIN_DIM))
        begin
            h_eff = YW'(drs_pkg::MIN_DIM);
        end
        else if (32'(grid_height_reg) > 32'(MAX_HEIGHT))
        begin
            h_eff = YW'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = YW'(grid_height_reg);
        end

        w_end = w_eff + XW'(1);
        h_end = h_eff + YW'(1);
    end

    // Stall everything while a finished result waits
    assign en       = !out_valid || out_ready;
    assign in_ready = en;
    assign accept   = in_valid && in_ready;

    // Padded position of the incoming item and its result tag
    always_comb
    begin
        px = frame_start ? XW'(0) : col_reg;
        py = frame_start ? YW'(0) : row_reg;
        has_result = (py >= YW'(2)) && (py <= h_end) && (px != XW'(0)) && (px <= w_eff);
        meta.x     = drs_pkg::IDX_BITS'(px - XW'(1));
        meta.y     = drs_pkg::IDX_BITS'(py - YW'(2));
        meta.last  = (px == w_eff) && (py == h_end);
    end

    // Step the raster position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            if (px >= w_end)
            begin
                col_reg <= '0;
                row_reg <= (py >= h_end) ? YW'(0) : py + YW'(1);
            end
            else
            begin
                col_reg <= px + XW'(1);
                row_reg <= py;
            end
        end
    end

    drs_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_store (
        .clk        (clk),
        .access_en  (accept),
        .col        (px),
        .row_odd    (py[0]),
        .new_value  (new_value),
        .old_value  (old_value),
        .east_data  (east_data),
        .north_data (north_data),
        .old_data   (old_data)
    );

    drs_window u_window (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .accept      (accept),
        .has_result  (has_result),
        .first_col   (px == XW'(0)),
        .south_value (new_value),
        .meta        (meta),
        .east_data   (east_data),
        .north_data  (north_data),
        .old_data    (old_data),
        .ops_valid   (ops_valid),
        .ops         (ops),
        .ops_meta    (ops_meta)
    );

    drs_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .ops_valid   (ops_valid),
        .ops         (ops),
        .ops_meta    (ops_meta),
        .alpha_coeff (alpha_coeff_reg),
        .beta_coeff  (beta_coeff_reg),
        .out_valid   (out_valid),
        .residual    (residual),
        .out_meta    (out_meta),
        .saturated   (saturated)
    );

    assign point_x    = out_meta.x;
    assign point_y    = out_meta.y;
    assign frame_last = out_meta.last;

endmodule

[sv/drs_checker.sv]
// Port-level checks for the diffusion-reaction stencil, bound to the top level.
// Depends on drs_pkg and diffusion_reaction_stencil.

module drs_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic signed [drs_pkg::RES_BITS-1:0] residual,
    input logic                                saturated
);

    // Hold a stalled residual
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(residual))
        else $error("stalled residual changed or dropped");

    // Never refuse an item while the output stage is empty
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // Clip only to the range limits
    a_sat_limits: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |->
            (residual == $signed(drs_pkg::RES_MAX)) || (residual == $signed(drs_pkg::RES_MIN)))
        else $error("saturated residual not at a range limit");

endmodule

bind diffusion_reaction_stencil drs_checker u_drs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .residual  (residual),
    .saturated (saturated)
);

[tb/sv/drs_residual_check.sv]
// Residual checker for the diffusion-reaction stencil testbench.
// Watches the input, output and register channels, predicts each residual and
// compares it field by field. Depends on drs_pkg.

module drs_residual_check #(
    parameter int MAX_WIDTH  = drs_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = drs_pkg::MAX_HEIGHT_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic                                  in_ready,
    input  logic signed [drs_pkg::VALUE_BITS-1:0] new_value,
    input  logic signed [drs_pkg::VALUE_BITS-1:0] old_value,
    input  logic                                  frame_start,
    input  logic                                  out_valid,
    input  logic                                  out_ready,
    input  logic signed [drs_pkg::RES_BITS-1:0]   residual,
    input  logic [drs_pkg::IDX_BITS-1:0]          point_x,
    input  logic [drs_pkg::IDX_BITS-1:0]          point_y,
    input  logic                                  frame_last,
    input  logic                                  saturated,
    input  logic                                  cfg_valid,
    input  logic                                  cfg_ready,
    input  logic [drs_pkg::CFG_BITS-1:0]          cfg_index,
    input  logic [drs_pkg::COEF_BITS-1:0]         cfg_data,
    output int                                    failures,
    output int                                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROW_SLOTS = MAX_WIDTH + 2;
    localparam int VB        = drs_pkg::VALUE_BITS;
    localparam int RB        = drs_pkg::RES_BITS;
    localparam int IB        = drs_pkg::IDX_BITS;
    localparam int DB        = drs_pkg::DIM_BITS;
    localparam int CB        = drs_pkg::COEF_BITS;

    typedef struct packed {
        logic [RB-1:0] residual;
        logic [IB-1:0] x;
        logic [IB-1:0] y;
        logic          last;
        logic          sat;
    } residual_rec_t;

    // Two padded rows of new values and one of old values
    logic signed [VB-1:0] new_rows [0:2*ROW_SLOTS-1];
    logic signed [VB-1:0] old_row [0:ROW_SLOTS];

    int unsigned   col_pos;
    int unsigned   row_pos;
    logic [DB-1:0] width_reg;
    logic [DB-1:0] height_reg;
    logic [CB-1:0] alpha_reg;
    logic [CB-1:0] beta_reg;

    residual_rec_t due_residuals[$];
    int            mismatch_count = 0;

    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
        if (v < drs_pkg::MIN_DIM)
            return drs_pkg::MIN_DIM;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Form the exact sum at Q.64, round once to Q.24 and clip to 48 bits
    function automatic residual_rec_t predict_residual(
        input logic signed [VB-1:0] west,
        input logic signed [VB-1:0] east,
        input logic signed [VB-1:0] north,
        input logic signed [VB-1:0] south,
        input logic signed [VB-1:0] center,
        input logic signed [VB-1:0] prior
    );
        logic signed [127:0] c;
        logic signed [127:0] lin;
        logic signed [127:0] alpha_w;
        logic signed [127:0] beta_w;
        logic signed [127:0] acc;
        logic signed [127:0] shifted;
        logic signed [127:0] hi_lim;
        logic signed [127:0] lo_lim;
        residual_rec_t       r;
        c       = center;
        lin     = west + east + north + south - 4 * c;
        alpha_w = {96'b0, alpha_reg};
        beta_w  = {96'b0, beta_reg};
        acc     = (lin <<< 40) + (((prior - c) * alpha_w) <<< 24)
                + c * ((128'sd1 <<< drs_pkg::FRAC_BITS) - c) * beta_w + (128'sd1 <<< 39);
        shifted = acc >>> drs_pkg::ACC_SHIFT;
        hi_lim  = (128'sd1 <<< (RB - 1)) - 1;
        lo_lim  = -(128'sd1 <<< (RB - 1));
        r = '0;
        if (shifted > hi_lim) begin
            r.residual = drs_pkg::RES_MAX;
            r.sat      = 1'b1;
        end
        else if (shifted < lo_lim) begin
            r.residual = drs_pkg::RES_MIN;
            r.sat      = 1'b1;
        end
        else begin
            r.residual = shifted[RB-1:0];
        end
        return r;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Take one grid point: predict its residual, update the rows, step the position
    task automatic absorb_point(
        input logic signed [VB-1:0] nv,
        input logic signed [VB-1:0] ov,
        input logic                 fs
    );
        int unsigned   w;
        int unsigned   h;
        int unsigned   px;
        int unsigned   py;
        int unsigned   cur;
        int unsigned   prv;
        residual_rec_t rec;
        w = clamp_dim(width_reg, MAX_WIDTH);
        h = clamp_dim(height_reg, MAX_HEIGHT);
        if (fs) begin
            col_pos = 0;
            row_pos = 0;
        end
        px  = col_pos;
        py  = row_pos;
        cur = (py & 1) * ROW_SLOTS;
        prv = ((py + 1) & 1) * ROW_SLOTS;

        // The point just below an interior point completes its stencil
        if (py >= 2 && py <= h + 1 && px >= 1 && px <= w) begin
            rec = predict_residual(new_rows[prv + px - 1], new_rows[prv + px + 1],
                                   new_rows[cur + px], nv, new_rows[prv + px], old_row[px]);
            rec.x    = IB'(px - 1);
            rec.y    = IB'(py - 2);
            rec.last = (px == w && py == h + 1);
            due_residuals.push_back(rec);
        end

        if (px < ROW_SLOTS) begin
            new_rows[cur + px] = nv;
            old_row[px]        = ov;
        end

        // Advance column, wrap to the next row and then to the next frame
        if (px >= w + 1) begin
            col_pos = 0;
            row_pos = (py >= h + 1) ? 0 : py + 1;
        end
        else begin
            col_pos = px + 1;
        end
    endtask

    task automatic match_residual();
        residual_rec_t want;
        if (due_residuals.size() == 0) begin
            flag_mismatch($sformatf("unexpected residual %h at (%0d,%0d)",
                                    residual, point_x, point_y));
        end
        else begin
            want = due_residuals.pop_front();
            if (residual !== want.residual)
                flag_mismatch($sformatf("residual at (%0d,%0d): got %h want %h",
                                        want.x, want.y, residual, want.residual));
            if (point_x !== want.x)
                flag_mismatch($sformatf("point_x: got %0d want %0d", point_x, want.x));
            if (point_y !== want.y)
                flag_mismatch($sformatf("point_y: got %0d want %0d", point_y, want.y));
            if (frame_last !== want.last)
                flag_mismatch($sformatf("frame_last at (%0d,%0d): got %b want %b",
                                        want.x, want.y, frame_last, want.last));
            if (saturated !== want.sat)
                flag_mismatch($sformatf("saturated at (%0d,%0d): got %b want %b",
                                        want.x, want.y, saturated, want.sat));
        end
    endtask

    // Track every handshake at the clock edge
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            col_pos    = 0;
            row_pos    = 0;
            width_reg  = DB'(128);
            height_reg = DB'(128);
            alpha_reg  = '0;
            beta_reg   = '0;
            due_residuals.delete();
            pending  <= 0;
            failures <= 0;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    drs_pkg::REG_GRID_WIDTH:  width_reg  = cfg_data[DB-1:0];
                    drs_pkg::REG_GRID_HEIGHT: height_reg = cfg_data[DB-1:0];
                    drs_pkg::REG_ALPHA_COEFF: alpha_reg  = cfg_data;
                    drs_pkg::REG_BETA_COEFF:  beta_reg   = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                absorb_point(new_value, old_value, frame_start);
            if (out_valid && out_ready)
                match_residual();
            pending  <= due_residuals.size();
            failures <= mismatch_count;
        end
    end

endmodule

[tb/sv/diffusion_reaction_stencil_tb.sv]
// Top of the diffusion-reaction stencil testbench: clock, reset, stimulus and verdict.
// Depends on drs_pkg, diffusion_reaction_stencil and drs_residual_check.

module diffusion_reaction_stencil_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 1000;
    localparam int SETTLE_CYCLES = 30;
    localparam int RANDOM_POINTS = 200;
    localparam int VB = drs_pkg::VALUE_BITS;
    localparam int CB = drs_pkg::COEF_BITS;

    logic                                  clk = 1'b0;
    logic                                  rst_n;
    logic                                  in_valid;
    logic                                  in_ready;
    logic signed [VB-1:0]                  new_value;
    logic signed [VB-1:0]                  old_value;
    logic                                  frame_start;
    logic                                  out_valid;
    logic                                  out_ready;
    logic signed [drs_pkg::RES_BITS-1:0]   residual;
    logic [drs_pkg::IDX_BITS-1:0]          point_x;
    logic [drs_pkg::IDX_BITS-1:0]          point_y;
    logic                                  frame_last;
    logic                                  saturated;
    logic                                  cfg_valid;
    logic                                  cfg_ready;
    logic [drs_pkg::CFG_BITS-1:0]          cfg_index;
    logic [CB-1:0]                         cfg_data;

    int failures;
    int pending;

    bit          gap_ok = 1'b1;
    bit          stall_ok = 1'b1;
    bit          aligned = 1'b1;
    int          stall_left = 0;
    int          quiet_cycles = 0;
    int unsigned points_sent = 0;

    diffusion_reaction_stencil dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .new_value   (new_value),
        .old_value   (old_value),
        .frame_start (frame_start),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .residual    (residual),
        .point_x     (point_x),
        .point_y     (point_y),
        .frame_last  (frame_last),
        .saturated   (saturated),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    drs_residual_check residual_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .new_value   (new_value),
        .old_value   (old_value),
        .frame_start (frame_start),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .residual    (residual),
        .point_x     (point_x),
        .point_y     (point_y),
        .frame_last  (frame_last),
        .saturated   (saturated),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .failures    (failures),
        .pending     (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hold the output back in bursts of random length
    always @(posedge clk)
    begin
        if (stall_left != 0) begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (stall_ok && rst_n && $urandom_range(0, 7) == 0) begin
            out_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 10);
        end
        else begin
            out_ready <= 1'b1;
        end
    end

    // Abort the run when no channel moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic logic [VB-1:0] extreme_value(input int unsigned k);
        case (k % 6)
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            4: return 32'h0100_0000;
            default: return 32'h0080_0000;
        endcase
    endfunction

    // Mode 0: concentrations near [0,1], 1: any bits, 2: extremes, 3: mix per point
    function automatic logic [VB-1:0] pick_value(input int mode);
        int m;
        m = (mode == 3) ? $urandom_range(0, 2) : mode;
        case (m)
            0: return 32'($urandom_range(0, 32'h0140_0000)) - 32'h0020_0000;
            1: return $urandom;
            default: return extreme_value($urandom_range(0, 5));
        endcase
    endfunction

    function automatic logic [CB-1:0] pick_coeff();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h0001_0000;
            3: return $urandom;
            default: return $urandom_range(0, 32'h0004_0000);
        endcase
    endfunction

    // Present one grid point and hold it until taken; valid stays high afterwards
    task automatic send_point(
        input logic [VB-1:0] nv,
        input logic [VB-1:0] ov,
        input logic          fs
    );
        if (gap_ok && $urandom_range(0, 7) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        new_value   <= nv;
        old_value   <= ov;
        frame_start <= fs;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        points_sent++;
    endtask

    task automatic write_reg(input logic [drs_pkg::CFG_BITS-1:0] idx,
                             input logic [CB-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic program_grid(
        input int unsigned   w,
        input int unsigned   h,
        input logic [CB-1:0] a,
        input logic [CB-1:0] b
    );
        write_reg(drs_pkg::REG_GRID_WIDTH, w);
        write_reg(drs_pkg::REG_GRID_HEIGHT, h);
        write_reg(drs_pkg::REG_ALPHA_COEFF, a);
        write_reg(drs_pkg::REG_BETA_COEFF, b);
        cfg_valid <= 1'b0;
    endtask

    // Drain every expected residual, then let points with no result leave the pipe
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Stream one padded frame; a cut-short frame leaves the position mid-frame
    task automatic send_frame(
        input int unsigned wu,
        input int unsigned hu,
        input int          mode,
        input bit          cut
    );
        int unsigned total;
        int unsigned stop;
        total = (wu + 2) * (hu + 2);
        stop  = cut ? $urandom_range(1, total - 1) : total;
        for (int unsigned i = 0; i < stop; i++)
            send_point(pick_value(mode), pick_value(mode),
                       (i == 0) && !(aligned && $urandom_range(0, 3) == 0));
        aligned = !cut;
    endtask

    task automatic run_phase(
        input int unsigned   w,
        input int unsigned   h,
        input logic [CB-1:0] a,
        input logic [CB-1:0] b,
        input int            frames
    );
        int unsigned wu;
        int unsigned hu;
        program_grid(w, h, a, b);
        wu = (w < drs_pkg::MIN_DIM) ? drs_pkg::MIN_DIM :
             ((w > drs_pkg::MAX_WIDTH_DEF) ? drs_pkg::MAX_WIDTH_DEF : w);
        hu = (h < drs_pkg::MIN_DIM) ? drs_pkg::MIN_DIM :
             ((h > drs_pkg::MAX_HEIGHT_DEF) ? drs_pkg::MAX_HEIGHT_DEF : h);
        for (int f = 0; f < frames; f++)
            send_frame(wu, hu, $urandom_range(0, 3),
                       (f + 1 < frames) && $urandom_range(0, 3) == 0);
        settle();
    endtask

    initial
    begin
        int unsigned start_count;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        new_value   = '0;
        old_value   = '0;
        frame_start = 1'b0;
        out_ready   = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = drs_pkg::REG_GRID_WIDTH;
        cfg_data    = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Smallest grid, one frame of extreme values with strong coupling
        program_grid(drs_pkg::MIN_DIM, drs_pkg::MIN_DIM, 32'hFFFF_FFFF, 32'h0001_0000);
        for (int unsigned i = 0; i < 25; i++)
            send_point(extreme_value(i), extreme_value(i + 3), i == 0);
        settle();

        // Wide and tall grids, and sizes below the usable range
        run_phase(24, drs_pkg::MIN_DIM, 32'hFFFF_FFFF, '0, 1);
        run_phase(drs_pkg::MIN_DIM, 24, '0, 32'hFFFF_FFFF, 1);
        run_phase(0, 1, pick_coeff(), pick_coeff(), 1);
        run_phase(1, 2, 32'h0001_0000, 32'h0001_0000, 2);

        // Random small grids and coefficients, idling switched per phase
        start_count = points_sent;
        while (points_sent - start_count < RANDOM_POINTS) begin
            gap_ok   = $urandom_range(0, 3) != 0;
            stall_ok = $urandom_range(0, 3) != 0;
            run_phase(($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10),
                      ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6),
                      pick_coeff(), pick_coeff(), $urandom_range(1, 3));
        end

        // Finish at full rate with no idling
        gap_ok   = 1'b0;
        stall_ok = 1'b0;
        repeat (2)
            run_phase($urandom_range(3, 8), $urandom_range(3, 5), pick_coeff(), pick_coeff(), 2);

        if (failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[filelist.f]
sv/drs_pkg.sv
sv/drs_line_store.sv
sv/drs_window.sv
sv/drs_datapath.sv
sv/diffusion_reaction_stencil.sv
sv/drs_checker.sv
tb/sv/drs_residual_check.sv
tb/sv/diffusion_reaction_stencil_tb.sv
